/* src/rpc_pkg.sv */
// Package for the span position cache: field widths, operation codes and transaction types.
`default_nettype none
package rpc_pkg;

  localparam int POS_W       = 48;
  localparam int HANDLE_W    = 32;
  localparam int HITS_W      = 16;
  localparam int FUNC_W      = 3;
  localparam int ENTRIES_DEF = 8;

  localparam logic [HITS_W-1:0] HITS_MAX = '1;

  localparam logic [FUNC_W-1:0] FN_LOOKUP = 3'd0;
  localparam logic [FUNC_W-1:0] FN_FILL   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DELETE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_LENGTH = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [POS_W-1:0]    position;
    logic [POS_W-1:0]    amount;
    logic [HANDLE_W-1:0] block_handle;
  } req_t;

  typedef struct packed {
    logic                hit;
    logic                nonempty;
    logic [POS_W-1:0]    position_out;
    logic [HANDLE_W-1:0] handle_out;
  } res_t;

endpackage
`default_nettype wire

/* src/rpc_select.sv */
// Parallel search over the cache slots: lookup hit and nearest span, fill slot choice.
`default_nettype none
module rpc_select #(
  parameter int ENTRIES = rpc_pkg::ENTRIES_DEF
) (
  input  wire logic [rpc_pkg::FUNC_W-1:0]   func,
  input  wire logic [rpc_pkg::POS_W-1:0]    position,
  input  wire logic [ENTRIES-1:0]           valid,
  input  wire logic [rpc_pkg::POS_W-1:0]    start    [ENTRIES],
  input  wire logic [rpc_pkg::POS_W-1:0]    length   [ENTRIES],
  input  wire logic [rpc_pkg::HANDLE_W-1:0] handle   [ENTRIES],
  input  wire logic [rpc_pkg::HITS_W-1:0]   hits     [ENTRIES],
  output rpc_pkg::res_t                     res,
  output logic [ENTRIES-1:0]                hit_oh,
  output logic [ENTRIES-1:0]                fill_oh
);

  localparam int LEVELS = (ENTRIES > 1) ? $clog2(ENTRIES) : 0;
  localparam int NP     = 1 << LEVELS;
  localparam int NODES  = 2 * NP - 1;
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [rpc_pkg::POS_W:0]    diff      [ENTRIES];
  logic [rpc_pkg::POS_W-1:0]  span_dist [ENTRIES];
  logic [ENTRIES-1:0]         contain;
  logic [ENTRIES-1:0]         same_start;
  logic [ENTRIES-1:0]         free;
  logic [ENTRIES-1:0]         free_oh;
  logic [ENTRIES-1:0]         below_free;
  logic [ENTRIES-1:0]         first_hit;
  logic [ENTRIES-1:0]         lfu_oh;
  logic                       blocked;

  // nearest-start tree: lower slot wins on equal distance
  logic                       nv [NODES];
  logic [rpc_pkg::POS_W-1:0]  nd [NODES];
  logic [rpc_pkg::POS_W-1:0]  ns [NODES];
  logic [rpc_pkg::HANDLE_W-1:0] nh [NODES];

  // fewest-hits tree: higher slot wins on equal count
  logic                       lv [NODES];
  logic [rpc_pkg::HITS_W-1:0] lh [NODES];
  logic [IDX_W-1:0]           li [NODES];

  genvar g;
  generate
    for (g = 0; g < NP; g++) begin : g_leaf
      if (g < ENTRIES) begin : g_used
        assign diff[g]       = {1'b0, position} - {1'b0, start[g]};
        assign span_dist[g]  = diff[g][rpc_pkg::POS_W] ? (start[g] - position)
                                                       : diff[g][rpc_pkg::POS_W-1:0];
        assign contain[g]    = valid[g] && !diff[g][rpc_pkg::POS_W] &&
                               (diff[g][rpc_pkg::POS_W-1:0] < length[g]);
        assign same_start[g] = valid[g] && (start[g] == position);
        assign nv[NP-1+g]    = valid[g];
        assign nd[NP-1+g]    = span_dist[g];
        assign ns[NP-1+g]    = start[g];
        assign nh[NP-1+g]    = handle[g];
        assign lv[NP-1+g]    = 1'b1;
        assign lh[NP-1+g]    = hits[g];
        assign li[NP-1+g]    = IDX_W'(g);
      end else begin : g_pad
        assign nv[NP-1+g] = 1'b0;
        assign nd[NP-1+g] = '0;
        assign ns[NP-1+g] = '0;
        assign nh[NP-1+g] = '0;
        assign lv[NP-1+g] = 1'b0;
        assign lh[NP-1+g] = '0;
        assign li[NP-1+g] = '0;
      end
    end

    for (g = 0; g < NP - 1; g++) begin : g_node
      logic near_sel;
      logic lfu_sel;
      assign near_sel = nv[2*g+2] && (!nv[2*g+1] || (nd[2*g+2] < nd[2*g+1]));
      assign nv[g]    = nv[2*g+1] || nv[2*g+2];
      assign nd[g]    = near_sel ? nd[2*g+2] : nd[2*g+1];
      assign ns[g]    = near_sel ? ns[2*g+2] : ns[2*g+1];
      assign nh[g]    = near_sel ? nh[2*g+2] : nh[2*g+1];
      assign lfu_sel  = lv[2*g+2] && (!lv[2*g+1] || (lh[2*g+2] <= lh[2*g+1]));
      assign lv[g]    = lv[2*g+1] || lv[2*g+2];
      assign lh[g]    = lfu_sel ? lh[2*g+2] : lh[2*g+1];
      assign li[g]    = lfu_sel ? li[2*g+2] : li[2*g+1];
    end
  endgenerate

  assign first_hit  = contain & (~contain + ENTRIES'(1));
  assign free       = ~valid;
  assign free_oh    = free & (~free + ENTRIES'(1));
  assign below_free = free_oh - ENTRIES'(1);
  assign blocked    = |(same_start & below_free);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      lfu_oh[i] = (li[0] == IDX_W'(i));
    end
  end

  always_comb begin
    logic [rpc_pkg::POS_W-1:0]    hit_off;
    logic [rpc_pkg::HANDLE_W-1:0] hit_hdl;
    hit_off = '0;
    hit_hdl = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_off = hit_off | ({rpc_pkg::POS_W{first_hit[i]}} & diff[i][rpc_pkg::POS_W-1:0]);
      hit_hdl = hit_hdl | ({rpc_pkg::HANDLE_W{first_hit[i]}} & handle[i]);
    end
    res     = '0;
    hit_oh  = '0;
    fill_oh = '0;
    unique case (func)
      rpc_pkg::FN_LOOKUP: begin
        hit_oh       = first_hit;
        res.hit      = |contain;
        res.nonempty = nv[0];
        if (|contain) begin
          res.position_out = hit_off;
          res.handle_out   = hit_hdl;
        end else if (nv[0]) begin
          res.position_out = ns[0];
          res.handle_out   = nh[0];
        end
      end
      rpc_pkg::FN_FILL: begin
        if (!blocked) begin
          fill_oh = (|free) ? free_oh : lfu_oh;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* src/range_position_cache_lfu_core.sv */
// Top level of the span position cache with least-frequently-used replacement.
//
//   channel | ports                        | payload
//   --------+------------------------------+-----------------------------------------
//   input   | in_tvalid/in_tready          | tuser: func; tdata: position, amount,
//           | in_tdata[127:0] in_tuser[2:0]|   block_handle
//   result  | out_tvalid/out_tready        | tuser: hit, nonempty; tdata: position_out,
//           | out_tdata[79:0] out_tuser[1:0]|   handle_out
//
// One transaction per cycle while the result side is not stalled; every input transaction gives exactly one result.
// Path: input register, one pass over all slots in parallel, result register.
// The slot table is updated at the edge where the item leaves the input register, so the
// following item sees it. Synchronous active-low reset clears all valid bits at once.
// A stalled result register holds the input register; in_tready then drops if it holds an item.
`default_nettype none
module range_position_cache_lfu_core #(
  parameter int ENTRIES = rpc_pkg::ENTRIES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // position[47:0], amount[95:48], block_handle[127:96]
  input  wire logic [2:0]   in_tuser,   // func[2:0]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [79:0]       out_tdata,  // position_out[47:0], handle_out[79:48]
  output logic [1:0]        out_tuser   // hit[0], nonempty[1]
);

  rpc_pkg::req_t s1_req_r;
  logic          s1_valid_r;
  rpc_pkg::res_t out_res_r;
  logic          out_valid_r;
  logic          adv;
  logic          s1_fire;

  logic [ENTRIES-1:0]             valid_r;
  logic [rpc_pkg::POS_W-1:0]      start_r  [ENTRIES];
  logic [rpc_pkg::POS_W-1:0]      len_r    [ENTRIES];
  logic [rpc_pkg::HANDLE_W-1:0]   handle_r [ENTRIES];
  logic [rpc_pkg::HITS_W-1:0]     hits_r   [ENTRIES];

  rpc_pkg::res_t      res;
  logic [ENTRIES-1:0] hit_oh;
  logic [ENTRIES-1:0] fill_oh;
  logic [ENTRIES-1:0] start_ge;
  logic [ENTRIES-1:0] handle_eq;

  assign adv       = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && adv;
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_req_r.func         <= in_tuser;
      s1_req_r.position     <= in_tdata[47:0];
      s1_req_r.amount       <= in_tdata[95:48];
      s1_req_r.block_handle <= in_tdata[127:96];
    end
  end

  rpc_select #(
    .ENTRIES(ENTRIES)
  ) u_select (
    .func     (s1_req_r.func),
    .position (s1_req_r.position),
    .valid    (valid_r),
    .start    (start_r),
    .length   (len_r),
    .handle   (handle_r),
    .hits     (hits_r),
    .res      (res),
    .hit_oh   (hit_oh),
    .fill_oh  (fill_oh)
  );

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      start_ge[i]  = valid_r[i] && (start_r[i] >= s1_req_r.position);
      handle_eq[i] = valid_r[i] && (handle_r[i] == s1_req_r.block_handle);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (s1_fire) begin
      for (int i = 0; i < ENTRIES; i++) begin
        unique case (s1_req_r.func)
          rpc_pkg::FN_FILL:   if (fill_oh[i]) valid_r[i] <= 1'b1;
          rpc_pkg::FN_DELETE: if (start_ge[i]) valid_r[i] <= 1'b0;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      for (int i = 0; i < ENTRIES; i++) begin
        unique case (s1_req_r.func)
          rpc_pkg::FN_LOOKUP: begin
            if (hit_oh[i] && (hits_r[i] != rpc_pkg::HITS_MAX)) begin
              hits_r[i] <= hits_r[i] + rpc_pkg::HITS_W'(1);
            end
          end
          rpc_pkg::FN_FILL: begin
            if (fill_oh[i]) begin
              start_r[i]  <= s1_req_r.position;
              len_r[i]    <= s1_req_r.amount;
              handle_r[i] <= s1_req_r.block_handle;
              hits_r[i]   <= '0;
            end
          end
          rpc_pkg::FN_INSERT: begin
            if (start_ge[i]) start_r[i] <= start_r[i] + s1_req_r.amount;
          end
          rpc_pkg::FN_LENGTH: begin
            if (handle_eq[i]) len_r[i] <= s1_req_r.amount;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.handle_out, out_res_r.position_out};
  assign out_tuser  = {out_res_r.nonempty, out_res_r.hit};

`ifndef SYNTHESIS
  a_hit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[1])
    else $error("hit reported on an empty cache");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> (out_tdata == '0))
    else $error("non-zero payload without a valid entry");

  a_select_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> ($onehot0(hit_oh) && $onehot0(fill_oh)))
    else $error("more than one slot selected");

  a_fill_valid: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (s1_req_r.func == rpc_pkg::FN_FILL) && (|fill_oh)
      |=> ((valid_r & $past(fill_oh)) == $past(fill_oh)))
    else $error("filled slot not valid");

  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_tvalid)
    else $error("result lost after processing");
`endif

endmodule
`default_nettype wire
